[rtl/core/region_membrane_and_boundary_cost_assert.svh]
// ----------------------------------------------------------------------------
// region membrane and boundary cost assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef REGION_MEMBRANE_AND_BOUNDARY_COST_ASSERT_SVH
`define REGION_MEMBRANE_AND_BOUNDARY_COST_ASSERT_SVH

// same-cycle implication, off during reset
`define RMBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define RMBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant that holds at every edge out of reset
`define RMBC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

[rtl/core/rmbc_pkg.sv]
// ----------------------------------------------------------------------------
// rmbc_pkg
// item types, widths and the membrane cost table functions for the region cost block
// ----------------------------------------------------------------------------
package rmbc_pkg;

	localparam int COORD_W  = 6;
	localparam int VALUE_W  = 8;
	localparam int COST_W   = 19;
	localparam int SUM_W    = 31;
	localparam int CRACK_W  = 15;
	localparam int SLICE_W  = 39;
	localparam int WEIGHT_W = 16;
	localparam int WEIGHT_FRAC = 8;
	localparam int ROM_DEPTH   = 256;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
	localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
	localparam logic [CRACK_W-1:0]  CRACK_MAX    = {CRACK_W{1'b1}};

	// row memory is split in three banks by row modulo three
	localparam int NUM_BANKS   = 3;
	localparam int BANK_SEL_W  = 2;
	localparam int ROW_NUM_W   = COORD_W + 1;
	localparam int ROW_QUOT_W  = 5;
	// y / 3 as (y * 43) >> 7, exact for six-bit y
	localparam int DIV3_PROD_W = 13;
	localparam logic [DIV3_PROD_W-1:0] DIV3_MUL = 13'd43;
	localparam int DIV3_SHIFT  = 7;

	// table generation constants
	localparam logic [63:0] LN2_Q30   = 64'd744261118;
	localparam logic [63:0] ROM_ROUND = 64'd8192;
	localparam int          ROM_SHIFT = 14;
	localparam logic [31:0] PROB_FULL = 32'd255;
	localparam logic [31:0] CLAMP_D   = 32'd1000;
	localparam logic [31:0] CLAMP_A   = 32'd1;
	localparam logic [31:0] CLAMP_B   = 32'd999;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [VALUE_W-1:0] membrane_value;
		logic               last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [SLICE_W-1:0] slice_cost;
		logic [CRACK_W-1:0] boundary_length;
	} result_t;

	// series term p / (2j + 1)
	function automatic logic [63:0] odd_div(input logic [63:0] p, input int j);
		logic [63:0] r;
		unique case (j)
			0: r = p;
			1: r = p / 3;
			2: r = p / 5;
			3: r = p / 7;
			4: r = p / 9;
			5: r = p / 11;
			6: r = p / 13;
			7: r = p / 15;
			8: r = p / 17;
			9: r = p / 19;
			10: r = p / 21;
			11: r = p / 23;
			12: r = p / 25;
			13: r = p / 27;
			14: r = p / 29;
			15: r = p / 31;
			16: r = p / 33;
			17: r = p / 35;
			18: r = p / 37;
			19: r = p / 39;
			default: r = '0;
		endcase
		return r;
	endfunction

	// natural log in unsigned q30 via atanh series, elaboration only
	function automatic logic [63:0] ln_q30(input logic [31:0] n);
		logic [5:0]  k;
		logic [63:0] base;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] rem;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] sum;
		k = '0;
		rem = '0;
		t = '0;
		sum = '0;
		if (n == 32'd0) begin
			return 64'd0;
		end
		for (int i = 1; i < 32; i++) begin
			if ((n >> i) != 32'd0) begin
				k = 6'(i);
			end
		end
		base = 64'd1 << k;
		num = (64'(n) - base) << 30;
		den = 64'(n) + base;
		// restoring long division
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				t[i] = 1'b1;
			end
		end
		t2 = (t * t) >> 30;
		p = t;
		for (int j = 0; j < 20; j++) begin
			sum = sum + odd_div(p, j);
			p = (p * t2) >> 30;
		end
		return 64'(k) * LN2_Q30 + (sum << 1);
	endfunction

	// cost -ln(p) - ln(1 - p) in q3.16, clamped at both ends
	function automatic logic [COST_W-1:0] cost_entry(input logic [VALUE_W-1:0] v);
		logic [31:0] d;
		logic [31:0] a;
		logic [31:0] b;
		logic [63:0] c;
		if (v == '0 || v == '1) begin
			d = CLAMP_D;
			a = CLAMP_A;
			b = CLAMP_B;
		end else begin
			d = PROB_FULL;
			a = 32'(v);
			b = PROB_FULL - 32'(v);
		end
		c = (ln_q30(d) << 1) - ln_q30(a) - ln_q30(b);
		return COST_W'((c + ROM_ROUND) >> ROM_SHIFT);
	endfunction

endpackage

[rtl/core/rmbc_ram.sv]
// ----------------------------------------------------------------------------
// rmbc_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rmbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 22
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read before write on a shared address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/region_membrane_and_boundary_cost.sv]
// ----------------------------------------------------------------------------
// region_membrane_and_boundary_cost
// per-region membrane data cost plus weighted four-neighbour boundary length
// ----------------------------------------------------------------------------
// Streams the pixels of one region, one item per clock while pixel_stall is
// low, with no gaps needed, each pixel carrying its box-relative coordinates
// and membrane byte. Every pixel adds -ln(p)-ln(1-p) (q3.16 table, p clamped to
// [0.001, 0.999]) to a saturating q15.16 sum; pixels inside the tile are marked
// in an occupancy bitmap and update the crack count by 4 minus 2 per set
// neighbour. The item with last_pixel set yields one result, sum + cracks *
// weight_potts (q8.8), saturated to 39 bits, which passes through the stage 2
// and result registers to the result port; the region state empties as that
// item leaves stage 1, so the next region can follow with no gap. Throughput
// is one pixel per cycle while pixel_stall is low: the bitmap lives in three
// row banks (row modulo three), so the rows above, at and below a pixel come
// out of three separate read ports, and a one-entry write bypass covers the
// row written by the pixel just before. Rows carry valid flags, so the bitmap
// empties with no clearing pass. The user must write weight_potts through the
// cfg channel only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module region_membrane_and_boundary_cost #(
	parameter int TILE_WIDTH  = 64,
	parameter int TILE_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel channel
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  rmbc_pkg::pixel_t              pixel,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output rmbc_pkg::result_t             result,
	// weight_potts write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rmbc_pkg::WEIGHT_W-1:0] cfg_data
);

	// only the first 64 rows and columns can ever be addressed
	localparam int COORD_SPAN = 1 << rmbc_pkg::COORD_W;
	localparam int COLS       = TILE_WIDTH < COORD_SPAN ? TILE_WIDTH : COORD_SPAN;
	localparam int ROWS       = TILE_HEIGHT < COORD_SPAN ? TILE_HEIGHT : COORD_SPAN;
	localparam int ROW_AW     = $clog2(ROWS);
	localparam int BANK_DEPTH = (ROWS + rmbc_pkg::NUM_BANKS - 1) / rmbc_pkg::NUM_BANKS;
	localparam int BANK_AW    = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
	localparam int EXT_W      = COORD_SPAN + 2;

	localparam int BSW = rmbc_pkg::BANK_SEL_W;
	localparam int QW  = rmbc_pkg::ROW_QUOT_W;
	localparam int RNW = rmbc_pkg::ROW_NUM_W;

	// ------------------------------------------------------------------
	// membrane cost table, built at elaboration
	// ------------------------------------------------------------------
	logic [rmbc_pkg::COST_W-1:0] cost_rom [rmbc_pkg::ROM_DEPTH];

	for (genvar g = 0; g < rmbc_pkg::ROM_DEPTH; g++) begin : g_rom
		localparam logic [rmbc_pkg::COST_W-1:0] ENTRY =
			rmbc_pkg::cost_entry(rmbc_pkg::VALUE_W'(g));
		assign cost_rom[g] = ENTRY;
	end

	// ------------------------------------------------------------------
	// handshake and stage control
	// ------------------------------------------------------------------
	logic accept;
	logic s1_vld_q;
	logic s1_adv;
	logic s2_vld_q;
	logic s2_adv;
	logic s2_free;
	logic s3_free;
	logic res_vld_q;

	assign s3_free     = ~res_vld_q | ~result_stall;
	assign s2_adv      = s2_vld_q & s3_free;
	assign s2_free     = ~s2_vld_q | s2_adv;
	// only a last pixel needs a free result slot to move on
	assign pixel_stall = s1_vld_q & ~s1_adv;
	assign accept      = pixel_valid & ~pixel_stall;
	assign cfg_ready   = 1'b1;

	// ------------------------------------------------------------------
	// input side: row bank mapping and memory read addresses
	// ------------------------------------------------------------------
	logic [rmbc_pkg::DIV3_PROD_W-1:0] y_prod;
	logic [QW-1:0]                    q_in;
	logic [rmbc_pkg::COORD_W-1:0]     y_three;
	logic [BSW-1:0]                   m_in;
	logic [BSW-1:0]                   bp_in;
	logic [BSW-1:0]                   bm_in;
	logic [QW-1:0]                    qp_in;
	logic [QW-1:0]                    qm_in;

	always_comb begin
		y_prod  = rmbc_pkg::DIV3_PROD_W'(pixel.pixel_y) * rmbc_pkg::DIV3_MUL;
		q_in    = QW'(y_prod >> rmbc_pkg::DIV3_SHIFT);
		y_three = rmbc_pkg::COORD_W'({q_in, 1'b0}) + rmbc_pkg::COORD_W'(q_in);
		m_in    = BSW'(pixel.pixel_y - y_three);
		// row below sits in the next bank, row above in the previous one
		if (m_in == BSW'(rmbc_pkg::NUM_BANKS - 1)) begin
			bp_in = '0;
			qp_in = q_in + QW'(1);
		end else begin
			bp_in = m_in + BSW'(1);
			qp_in = q_in;
		end
		if (m_in == '0) begin
			bm_in = BSW'(rmbc_pkg::NUM_BANKS - 1);
			qm_in = q_in - QW'(1);
		end else begin
			bm_in = m_in - BSW'(1);
			qm_in = q_in;
		end
	end

	// ------------------------------------------------------------------
	// stage 1 registers
	// ------------------------------------------------------------------
	logic [rmbc_pkg::COORD_W-1:0] x_s1;
	logic [rmbc_pkg::COORD_W-1:0] y_s1;
	logic                         last_s1;
	logic [rmbc_pkg::COST_W-1:0]  cost_s1;
	logic [BSW-1:0]               m_s1;
	logic [BSW-1:0]               bp_s1;
	logic [BSW-1:0]               bm_s1;
	logic [QW-1:0]                q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= pixel.pixel_x;
			y_s1    <= pixel.pixel_y;
			last_s1 <= pixel.last_pixel;
			cost_s1 <= cost_rom[pixel.membrane_value];
			m_s1    <= m_in;
			bp_s1   <= bp_in;
			bm_s1   <= bm_in;
			q_s1    <= q_in;
		end
	end

	assign s1_adv = s1_vld_q & (~last_s1 | s2_free);

	// ------------------------------------------------------------------
	// occupancy bitmap: three row banks
	// ------------------------------------------------------------------
	logic [COLS-1:0] bank_dout [rmbc_pkg::NUM_BANKS];
	logic            bm_wr;
	logic [COLS-1:0] row_new;

	for (genvar b = 0; b < rmbc_pkg::NUM_BANKS; b++) begin : g_bank
		logic [BANK_AW-1:0] rd_addr;

		always_comb begin
			if (m_in == BSW'(b)) begin
				rd_addr = BANK_AW'(q_in);
			end else if (bp_in == BSW'(b)) begin
				rd_addr = BANK_AW'(qp_in);
			end else begin
				rd_addr = BANK_AW'(qm_in);
			end
		end

		rmbc_ram #(
			.WIDTH(COLS),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk     (clk),
			.wr_en   (bm_wr && m_s1 == BSW'(b)),
			.wr_addr (BANK_AW'(q_s1)),
			.wr_data (row_new),
			.rd_en   (accept),
			.rd_addr (rd_addr),
			.rd_data (bank_dout[b])
		);
	end

	// row valid flags and the one-entry write bypass
	logic [ROWS-1:0]   rvalid_q;
	logic              wr_vld_q;
	logic [ROW_AW-1:0] wr_row_q;
	logic [COLS-1:0]   wr_data_q;

	function automatic logic [COLS-1:0] pick_row(
		input logic            present,
		input logic            hit,
		input logic            vld,
		input logic [COLS-1:0] mem_row,
		input logic [COLS-1:0] byp_row
	);
		logic [COLS-1:0] r;
		if (!present) begin
			r = '0;
		end else if (hit) begin
			r = byp_row;
		end else if (vld) begin
			r = mem_row;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stage 1 work: neighbours, cracks, data sum
	// ------------------------------------------------------------------
	logic [rmbc_pkg::SUM_W-1:0]   sum_q;
	logic [rmbc_pkg::CRACK_W-1:0] crack_q;

	logic [RNW-1:0]                 r0;
	logic [RNW-1:0]                 rp;
	logic [RNW-1:0]                 rm;
	logic                           e0;
	logic                           ep;
	logic                           em;
	logic                           in_tile;
	logic [COLS-1:0]                row0;
	logic [COLS-1:0]                rowp;
	logic [COLS-1:0]                rowm;
	logic [EXT_W-1:0]               ext0;
	logic [COORD_SPAN-1:0]          extp;
	logic [COORD_SPAN-1:0]          extm;
	logic [RNW-1:0]                 xi;
	logic                           self_set;
	logic [2:0]                     nbr;
	logic                           new_px;
	logic [rmbc_pkg::CRACK_W+1:0]   crack_plus;
	logic [rmbc_pkg::CRACK_W+1:0]   crack_minus;
	logic [rmbc_pkg::CRACK_W+1:0]   crack_diff;
	logic [rmbc_pkg::CRACK_W-1:0]   crack_clamp;
	logic [rmbc_pkg::CRACK_W-1:0]   crack_upd;
	logic [rmbc_pkg::SUM_W:0]       sum_add;
	logic [rmbc_pkg::SUM_W-1:0]     sum_upd;

	always_comb begin
		r0 = RNW'(y_s1);
		rp = r0 + RNW'(1);
		rm = r0 - RNW'(1);
		e0 = r0 < RNW'(ROWS);
		ep = rp < RNW'(ROWS);
		em = (y_s1 != '0) && e0;
		in_tile = (RNW'(x_s1) < RNW'(COLS)) && e0;

		row0 = pick_row(e0, wr_vld_q && wr_row_q == ROW_AW'(r0),
			rvalid_q[ROW_AW'(r0)], bank_dout[m_s1], wr_data_q);
		rowp = pick_row(ep, wr_vld_q && wr_row_q == ROW_AW'(rp),
			rvalid_q[ROW_AW'(rp)], bank_dout[bp_s1], wr_data_q);
		rowm = pick_row(em, wr_vld_q && wr_row_q == ROW_AW'(rm),
			rvalid_q[ROW_AW'(rm)], bank_dout[bm_s1], wr_data_q);

		// zero padding on both sides covers the tile edges
		ext0 = {1'b0, COORD_SPAN'(row0), 1'b0};
		extp = COORD_SPAN'(rowp);
		extm = COORD_SPAN'(rowm);
		xi   = RNW'(x_s1);

		self_set = ext0[xi + RNW'(1)];
		nbr = 3'(ext0[xi]) + 3'(ext0[xi + RNW'(2)]) + 3'(extp[x_s1]) + 3'(extm[x_s1]);
		new_px = in_tile & ~self_set;

		crack_plus  = (rmbc_pkg::CRACK_W + 2)'(crack_q) + (rmbc_pkg::CRACK_W + 2)'(4);
		crack_minus = (rmbc_pkg::CRACK_W + 2)'({nbr, 1'b0});
		crack_diff  = crack_plus - crack_minus;
		if (crack_plus < crack_minus) begin
			crack_clamp = '0;
		end else if (crack_diff > (rmbc_pkg::CRACK_W + 2)'(rmbc_pkg::CRACK_MAX)) begin
			crack_clamp = rmbc_pkg::CRACK_MAX;
		end else begin
			crack_clamp = rmbc_pkg::CRACK_W'(crack_diff);
		end
		crack_upd = new_px ? crack_clamp : crack_q;

		sum_add = {1'b0, sum_q} + (rmbc_pkg::SUM_W + 1)'(cost_s1);
		sum_upd = sum_add[rmbc_pkg::SUM_W] ? rmbc_pkg::SUM_MAX : sum_add[rmbc_pkg::SUM_W-1:0];

		row_new = row0 | ({{(COLS - 1){1'b0}}, 1'b1} << x_s1);
	end

	// the last pixel's own mark is dropped since the region empties anyway
	assign bm_wr = s1_adv & ~last_s1 & in_tile;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			crack_q  <= '0;
			rvalid_q <= '0;
			wr_vld_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				sum_q    <= '0;
				crack_q  <= '0;
				rvalid_q <= '0;
				wr_vld_q <= 1'b0;
			end else begin
				sum_q   <= sum_upd;
				crack_q <= crack_upd;
				if (in_tile) begin
					rvalid_q[ROW_AW'(r0)] <= 1'b1;
					wr_vld_q              <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bm_wr) begin
			wr_row_q  <= ROW_AW'(r0);
			wr_data_q <= row_new;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: finished region totals
	// ------------------------------------------------------------------
	logic [rmbc_pkg::SUM_W-1:0]   sum_s2;
	logic [rmbc_pkg::CRACK_W-1:0] crack_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			s2_vld_q <= 1'b1;
		end else if (s2_adv) begin
			s2_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			sum_s2   <= sum_upd;
			crack_s2 <= crack_upd;
		end
	end

	// ------------------------------------------------------------------
	// weight register
	// ------------------------------------------------------------------
	logic [rmbc_pkg::WEIGHT_W-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= rmbc_pkg::WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: weighted boundary term and result register
	// ------------------------------------------------------------------
	localparam int PROD_W  = rmbc_pkg::CRACK_W + rmbc_pkg::WEIGHT_W;
	localparam int TOTAL_W = rmbc_pkg::SLICE_W + 1;

	logic [PROD_W-1:0]             prod;
	logic [TOTAL_W-1:0]            total;
	logic [rmbc_pkg::SLICE_W-1:0]  slice;
	rmbc_pkg::result_t             result_q;

	always_comb begin
		prod  = PROD_W'(crack_s2) * PROD_W'(weight_q);
		total = TOTAL_W'(sum_s2) + TOTAL_W'({prod, {rmbc_pkg::WEIGHT_FRAC{1'b0}}});
		slice = total[TOTAL_W-1] ? '1 : total[rmbc_pkg::SLICE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (s2_adv) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			result_q.slice_cost      <= slice;
			result_q.boundary_length <= crack_s2;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = result_q;

endmodule

[rtl/core/rmbc_checker.sv]
// ----------------------------------------------------------------------------
// rmbc_checker
// port-level checks for the region cost block, bound to the top level
// ----------------------------------------------------------------------------
`include "region_membrane_and_boundary_cost_assert.svh"

module rmbc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_valid,
	input logic              pixel_stall,
	input rmbc_pkg::pixel_t  pixel,
	input logic              result_valid,
	input logic              result_stall,
	input rmbc_pkg::result_t result
);

	// three result slots at most: stage 1, stage 2 and the output register
	localparam logic [2:0] MAX_PENDING = 3'd3;

	logic       last_in;
	logic       res_out;
	logic [2:0] pending_q;

	assign last_in = pixel_valid & ~pixel_stall & pixel.last_pixel;
	assign res_out = result_valid & ~result_stall;

	// regions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(last_in) - 3'(res_out);
		end
	end

	`RMBC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "result dropped or changed while stalled")

	`RMBC_ASSERT_IMPLIES(a_no_orphan_result, clk, arst_n, result_valid, pending_q != 3'd0, "result without a last pixel")

	`RMBC_ASSERT_ALWAYS(a_pending_bound, clk, arst_n, pending_q <= MAX_PENDING, "more regions in flight than slots")

	`RMBC_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, pixel_stall, result_valid && result_stall, "pixel stall without a blocked result")

	`RMBC_ASSERT_IMPLIES(a_no_crack_cost, clk, arst_n, result_valid && result.boundary_length == '0, (result.slice_cost >> rmbc_pkg::SUM_W) == '0, "cost above data sum range with no cracks")

endmodule

bind region_membrane_and_boundary_cost rmbc_checker u_rmbc_checker (.*);
